FILE: src/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication checked on every rising clock edge outside reset
`define VFV_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked on every rising clock edge outside reset
`define VFV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/vfv_pkg.sv
// types and constants of the voxel face visibility block
package vfv_pkg;

   localparam int CHUNK_SIZE_DEF = 16;

   localparam int COORD_W = 4;
   localparam int FACE_W  = 6;

   // request kinds
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // face bit positions
   localparam int FACE_XN = 0;
   localparam int FACE_XP = 1;
   localparam int FACE_YN = 2;
   localparam int FACE_YP = 3;
   localparam int FACE_ZN = 4;
   localparam int FACE_ZP = 5;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_QUERY
   } vfv_state_type;

   // query step, named by the column word that sits on the read port
   typedef enum logic [2:0] {
      STEP_CENTER = 3'd1,
      STEP_XN     = 3'd2,
      STEP_XP     = 3'd3,
      STEP_YN     = 3'd4,
      STEP_YP     = 3'd5
   } vfv_step_type;

endpackage

FILE: src/vfv_ram.sv
// generic simple dual port ram with registered read
module vfv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/voxel_face_visibility_mask.sv
// top level of the voxel face visibility mask block
// query: no new request is taken until its face mask is loaded into the response
// write: read-modify-write of one z-column word, no response; holds off new requests
// the single read port of the column store sets the rate: five column words per query
// reset: synchronous; afterwards a clearing pass over all CHUNK_SIZE*CHUNK_SIZE column words
// zeroes the store, and no request is taken until it ends
`include "assert_macros.svh"

module voxel_face_visibility_mask #(
   parameter int CHUNK_SIZE = vfv_pkg::CHUNK_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // pos_x[3:0], pos_y[7:4], pos_z[11:8], solid[12], edge_left_solid[13],
   // edge_right_solid[14], edge_front_solid[15], edge_back_solid[16], zero pad[23:17]
   input  logic [23:0] req_tdata,
   // cmd[0]
   input  logic [0:0]  req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // face_mask[5:0], zero pad[7:6]
   output logic [7:0]  rsp_tdata
);

   import vfv_pkg::*;

   // store layout: one word per (x, y) column, one bit per z
   localparam int DEPTH = CHUNK_SIZE * CHUNK_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int ZW    = $clog2(CHUNK_SIZE);
   localparam int PW    = AW + 6;                 // room for 16*N+16 before truncation
   localparam int NW    = COORD_W + 1;            // neighbor coordinate may reach 16
   localparam logic [6:0] LIM = 7'(CHUNK_SIZE - 1);

   // request fields
   logic [COORD_W-1:0] in_x, in_y, in_z;
   logic               in_solid;
   logic [3:0]         in_edge;                   // left, right, front, back
   logic               in_cmd;
   logic               in_inside;
   logic               req_fire;

   assign in_x      = req_tdata[3:0];
   assign in_y      = req_tdata[7:4];
   assign in_z      = req_tdata[11:8];
   assign in_solid  = req_tdata[12];
   assign in_edge   = req_tdata[16:13];
   assign in_cmd    = req_tuser[0];
   assign in_inside = (7'(in_x) <= LIM) && (7'(in_y) <= LIM) && (7'(in_z) <= LIM);
   assign req_fire  = req_tvalid && req_tready;

   // control state
   vfv_state_type state_ff, state_in;
   vfv_step_type  step_ff, step_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;

   // item under work
   logic [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic               solid_ff, inside_ff;
   logic [3:0]         edge_ff;

   // neighbor occupancy gathered over the query steps
   logic center_ff, zn_ff, zp_ff, xn_ff, xp_ff, yn_ff;
   logic [FACE_W-1:0] rsp_mask_ff;

   // ram ports
   logic                  ram_wr_en, ram_rd_en;
   logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
   logic [CHUNK_SIZE-1:0] ram_wr_data, ram_rd_data;

   logic rsp_free;
   logic load_rsp;

   assign rsp_free = !rsp_tvalid_ff || rsp_tready;

   function automatic logic [AW-1:0] col_addr(input logic [NW-1:0] cx, input logic [NW-1:0] cy);
      col_addr = AW'(PW'(cx) * PW'(CHUNK_SIZE) + PW'(cy));
   endfunction

   // neighbor columns, clamped to the center at a chunk limit where they go unused
   logic [NW-1:0] cx, cy, nx_m, nx_p, ny_m, ny_p;
   logic          x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;

   assign cx   = NW'(x_ff);
   assign cy   = NW'(y_ff);
   assign x_lo = (x_ff == '0);
   assign y_lo = (y_ff == '0);
   assign z_lo = (z_ff == '0);
   assign x_hi = (7'(x_ff) == LIM);
   assign y_hi = (7'(y_ff) == LIM);
   assign z_hi = (7'(z_ff) == LIM);
   assign nx_m = x_lo ? cx : cx - NW'(1);
   assign nx_p = x_hi ? cx : cx + NW'(1);
   assign ny_m = y_lo ? cy : cy - NW'(1);
   assign ny_p = y_hi ? cy : cy + NW'(1);

   // bit positions inside a column word
   logic [ZW-1:0] zi, zi_m, zi_p;
   logic          rd_bit;

   assign zi     = ZW'(z_ff);
   assign zi_m   = ZW'(7'(z_ff) - 7'd1);
   assign zi_p   = ZW'(7'(z_ff) + 7'd1);
   assign rd_bit = ram_rd_data[zi];

   // face mask from the gathered bits, the last column word still on the read port
   logic [FACE_W-1:0] face_mask;

   always_comb begin
      face_mask          = '0;
      face_mask[FACE_XN] = x_lo ? !edge_ff[0] : !xn_ff;
      face_mask[FACE_XP] = x_hi ? !edge_ff[1] : !xp_ff;
      face_mask[FACE_YN] = y_lo || !yn_ff;
      face_mask[FACE_YP] = y_hi || !rd_bit;
      face_mask[FACE_ZN] = z_lo ? !edge_ff[2] : !zn_ff;
      face_mask[FACE_ZP] = z_hi ? !edge_ff[3] : !zp_ff;
      // empty voxel or coordinate outside the chunk
      if (!(inside_ff && center_ff)) begin
         face_mask = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               step_in  = STEP_CENTER;
               state_in = (in_cmd == CMD_QUERY) ? ST_QUERY : ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         ST_QUERY: begin
            unique case (step_ff)
               STEP_CENTER: step_in = STEP_XN;
               STEP_XN:     step_in = STEP_XP;
               STEP_XP:     step_in = STEP_YN;
               STEP_YN:     step_in = STEP_YP;
               STEP_YP: begin
                  if (rsp_free) begin
                     state_in = ST_IDLE;
                  end
               end
               default:     state_in = ST_IDLE;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready  = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = col_addr(NW'(in_x), NW'(in_y));
      ram_wr_en   = 1'b0;
      ram_wr_addr = col_addr(cx, cy);
      ram_wr_data = ram_rd_data;
      load_rsp    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
         end
         ST_IDLE: begin
            // the center column is fetched in the cycle the request is taken
            req_tready = 1'b1;
            ram_rd_en  = req_fire;
         end
         ST_WRITE: begin
            ram_wr_en       = inside_ff;
            ram_wr_data[zi] = solid_ff;
         end
         ST_QUERY: begin
            unique case (step_ff)
               STEP_CENTER: begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = col_addr(nx_m, cy);
               end
               STEP_XN: begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = col_addr(nx_p, cy);
               end
               STEP_XP: begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = col_addr(cx, ny_m);
               end
               STEP_YN: begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = col_addr(cx, ny_p);
               end
               STEP_YP: begin
                  // read port held so the last column stays put while the response waits
                  load_rsp = rsp_free;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (load_rsp) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         step_ff       <= STEP_CENTER;
         clr_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         clr_ff        <= clr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // item and gathered neighbor bits
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff      <= in_x;
         y_ff      <= in_y;
         z_ff      <= in_z;
         solid_ff  <= in_solid;
         edge_ff   <= in_edge;
         inside_ff <= in_inside;
      end
      if (state_ff == ST_QUERY) begin
         unique case (step_ff)
            STEP_CENTER: begin
               center_ff <= rd_bit;
               zn_ff     <= ram_rd_data[zi_m];
               zp_ff     <= ram_rd_data[zi_p];
            end
            STEP_XN: xn_ff <= rd_bit;
            STEP_XP: xp_ff <= rd_bit;
            STEP_YN: yn_ff <= rd_bit;
            STEP_YP: ;
            default: ;
         endcase
      end
      if (load_rsp) begin
         rsp_mask_ff <= face_mask;
      end
   end

   vfv_ram #(
      .WIDTH (CHUNK_SIZE),
      .DEPTH (DEPTH)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_mask_ff};

   // a taken request always starts a write or a query
   `VFV_ASSERT_NEXT(a_fire_starts_item, clock, reset, req_fire,
      (state_ff == ST_WRITE || state_ff == ST_QUERY), "request did not start an item")
   // the store is written only by the clearing pass or a write request
   `VFV_ASSERT(a_wr_source, clock, reset, ram_wr_en,
      (state_ff == ST_CLEAR || state_ff == ST_WRITE), "unexpected store write")
   // a store write never overlaps the taking of a new request
   `VFV_ASSERT(a_wr_not_fire, clock, reset, ram_wr_en, !req_fire,
      "store write while a request is taken")
   // a response appears only at the end of a query
   `VFV_ASSERT(a_rsp_from_query, clock, reset, $rose(rsp_tvalid_ff),
      ($past(state_ff) == ST_QUERY), "response not produced by a query")

endmodule

FILE: verif/vfv_checker.sv
// scoreboard for the voxel face visibility mask: own occupancy copy, face mask checks
module vfv_checker #(
   parameter int CHUNK_SIZE = vfv_pkg::CHUNK_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // pos_x[3:0], pos_y[7:4], pos_z[11:8], solid[12], edge_left_solid[13],
   // edge_right_solid[14], edge_front_solid[15], edge_back_solid[16], zero pad[23:17]
   input  logic [23:0] req_tdata,
   // cmd[0]
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // face_mask[5:0], zero pad[7:6]
   input  logic [7:0]  rsp_tdata,
   output int          mismatches,
   output int          outstanding,
   output int          writes_seen,
   output int          queries_seen,
   output int          partial_masks
);
   timeunit 1ns;
   timeprecision 1ps;

   import vfv_pkg::*;

   localparam int CELLS = CHUNK_SIZE * CHUNK_SIZE * CHUNK_SIZE;
   localparam int LIM   = CHUNK_SIZE - 1;

   typedef struct packed {
      logic [6:0]         pad;
      logic               edge_back, edge_front, edge_right, edge_left, solid;
      logic [COORD_W-1:0] z, y, x;
   } voxel_request_type;

   bit                occupied [CELLS];
   logic [FACE_W-1:0] due_masks [$];
   int                errors, writes, queries, partials;

   function automatic bit in_chunk(int x, int y, int z);
      return x <= LIM && y <= LIM && z <= LIM;
   endfunction

   function automatic bit solid_at(int x, int y, int z);
      if (!in_chunk(x, y, z)) return 1'b0;
      return occupied[(x * CHUNK_SIZE + y) * CHUNK_SIZE + z];
   endfunction

   // border faces follow the edge bits on x and z, y limits stay exposed
   function automatic logic [FACE_W-1:0] predict_face_mask(voxel_request_type r);
      int x, y, z;
      logic [FACE_W-1:0] m;
      x = r.x;
      y = r.y;
      z = r.z;
      if (!solid_at(x, y, z)) return '0;
      m = '1;
      if (x == 0 ? r.edge_left : solid_at(x - 1, y, z))    m[FACE_XN] = 1'b0;
      if (x == LIM ? r.edge_right : solid_at(x + 1, y, z)) m[FACE_XP] = 1'b0;
      if (y > 0 && solid_at(x, y - 1, z))                  m[FACE_YN] = 1'b0;
      if (y < LIM && solid_at(x, y + 1, z))                m[FACE_YP] = 1'b0;
      if (z == 0 ? r.edge_front : solid_at(x, y, z - 1))   m[FACE_ZN] = 1'b0;
      if (z == LIM ? r.edge_back : solid_at(x, y, z + 1))  m[FACE_ZP] = 1'b0;
      return m;
   endfunction

   always @(posedge clock) begin : scoreboard
      voxel_request_type r;
      logic [FACE_W-1:0] want;
      if (reset) begin
         foreach (occupied[i]) occupied[i] = 1'b0;
         due_masks.delete();
      end else begin
         // responses first: a mask always belongs to an earlier query
         if (rsp_tvalid && rsp_tready) begin
            if (due_masks.size() == 0) begin
               $display("%0t ns: face_mask expected none actual 0x%02h",
                        $time, rsp_tdata[FACE_W-1:0]);
               errors++;
            end else begin
               want = due_masks.pop_front();
               if (rsp_tdata[FACE_W-1:0] !== want) begin
                  $display("%0t ns: face_mask expected 0x%02h actual 0x%02h",
                           $time, want, rsp_tdata[FACE_W-1:0]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            r = voxel_request_type'(req_tdata);
            if (req_tuser[0] == CMD_QUERY) begin
               want = predict_face_mask(r);
               due_masks.push_back(want);
               queries++;
               if (want != '0 && want != '1) partials++;
            end else begin
               if (in_chunk(r.x, r.y, r.z))
                  occupied[(r.x * CHUNK_SIZE + r.y) * CHUNK_SIZE + r.z] = r.solid;
               writes++;
            end
         end
      end
      mismatches    <= errors;
      outstanding   <= due_masks.size();
      writes_seen   <= writes;
      queries_seen  <= queries;
      partial_masks <= partials;
   end

endmodule

FILE: verif/tb_voxel_face_visibility_mask.sv
// testbench top for the voxel face visibility mask: stimulus, response sink and verdict
module tb_voxel_face_visibility_mask;
   timeunit 1ns;
   timeprecision 1ps;

   import vfv_pkg::*;

   localparam int CHUNK          = CHUNK_SIZE_DEF;
   localparam int LIM            = CHUNK - 1;
   localparam int TOTAL_REQUESTS = 1650;
   // request count at which the response side takes its long break
   localparam int HOLD_AT        = 400;
   localparam int HOLD_CYCLES    = 300;
   // from here on neither side idles
   localparam int CALM_AT        = 1400;
   // margin kept after the last expected mask has arrived
   localparam int DRAIN_CYCLES   = 20;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // pos_x[3:0], pos_y[7:4], pos_z[11:8], solid[12], edge_left_solid[13],
   // edge_right_solid[14], edge_front_solid[15], edge_back_solid[16], zero pad[23:17]
   logic [23:0] req_tdata;
   // cmd[0]
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // face_mask[5:0], zero pad[7:6]
   logic [7:0]  rsp_tdata;

   int mismatches, outstanding, writes_seen, queries_seen, partial_masks;

   // shared knobs between the request and response processes
   bit tx_idle_on;
   bit rx_idle_on;
   bit hold_wanted;
   int requests_sent;
   int holds_done;

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   voxel_face_visibility_mask #(.CHUNK_SIZE(CHUNK)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // the checker sees both channels exactly as the block does
   vfv_checker #(.CHUNK_SIZE(CHUNK)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .writes_seen   (writes_seen),
      .queries_seen  (queries_seen),
      .partial_masks (partial_masks)
   );

   // one request: optional idle burst, then hold valid until the block takes it
   task automatic send_request(input logic cmd, input int x, y, z,
                               input int solid, el, er, ef, eb);
      int gap;
      gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'b0, 1'(eb), 1'(ef), 1'(er), 1'(el), 1'(solid),
                     COORD_W'(z), COORD_W'(y), COORD_W'(x)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   // coordinates lean toward the chunk borders, where the edge bits matter
   function automatic int border_biased();
      unique case ($urandom_range(0, 2))
         0:       return $urandom_range(0, 1);
         1:       return $urandom_range(LIM - 1, LIM);
         default: return $urandom_range(0, LIM);
      endcase
   endfunction

   // step at most one voxel away, clamped to the chunk
   function automatic int jitter(int c);
      int v;
      v = c + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > LIM) v = LIM;
      return v;
   endfunction

   initial begin : stimulus
      int ax, ay, az, n;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_WRITE;
      tx_idle_on  = 1'b1;
      rx_idle_on  = 1'b1;
      hold_wanted = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // empty store: any query answers zero, edge bits or not
      send_request(CMD_QUERY, 0, 0, 0, 1, 0, 0, 0, 0);
      send_request(CMD_QUERY, LIM, LIM, LIM, 0, 1, 1, 1, 1);
      // lone voxel in the low corner; edge bits on a write do nothing
      send_request(CMD_WRITE, 0, 0, 0, 1, 1, 1, 1, 1);
      send_request(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
      // left and front hidden by the edge bits, solid bit on a query ignored
      send_request(CMD_QUERY, 0, 0, 0, 0, 1, 1, 1, 1);
      // high corner: right and back from edge bits, top stays exposed
      send_request(CMD_WRITE, LIM, LIM, LIM, 1, 0, 0, 0, 0);
      send_request(CMD_QUERY, LIM, LIM, LIM, 1, 1, 1, 1, 1);
      // neighbours inside the chunk hide the shared faces
      send_request(CMD_WRITE, 1, 0, 0, 1, 0, 0, 0, 0);
      send_request(CMD_WRITE, 0, 1, 0, 1, 0, 0, 0, 0);
      send_request(CMD_WRITE, 0, 0, 1, 1, 0, 0, 0, 0);
      send_request(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
      send_request(CMD_QUERY, 1, 0, 0, 0, 1, 0, 1, 0);
      // clearing a voxel exposes its neighbour again and empties it
      send_request(CMD_WRITE, 1, 0, 0, 0, 0, 0, 0, 0);
      send_request(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
      send_request(CMD_QUERY, 1, 0, 0, 1, 1, 1, 1, 1);
      // fully enclosed voxel in the middle: solid but no face exposed
      send_request(CMD_WRITE, 8, 8, 8, 1, 0, 0, 0, 0);
      send_request(CMD_WRITE, 7, 8, 8, 1, 0, 0, 0, 0);
      send_request(CMD_WRITE, 9, 8, 8, 1, 0, 0, 0, 0);
      send_request(CMD_WRITE, 8, 7, 8, 1, 0, 0, 0, 0);
      send_request(CMD_WRITE, 8, 9, 8, 1, 0, 0, 0, 0);
      send_request(CMD_WRITE, 8, 8, 7, 1, 0, 0, 0, 0);
      send_request(CMD_WRITE, 8, 8, 9, 1, 0, 0, 0, 0);
      send_request(CMD_QUERY, 8, 8, 8, 0, 1, 1, 1, 1);
      send_request(CMD_QUERY, 9, 8, 8, 1, 0, 0, 0, 0);

      // ---- random part ----
      while (requests_sent < TOTAL_REQUESTS) begin
         if (requests_sent >= HOLD_AT && holds_done == 0 && !hold_wanted)
            hold_wanted = 1'b1;
         if (requests_sent >= CALM_AT) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
         end
         if ($urandom_range(0, 9) == 0) begin
            // noise: any request anywhere in the chunk
            send_request($urandom_range(0, 1) ? CMD_QUERY : CMD_WRITE,
                         $urandom_range(0, LIM), $urandom_range(0, LIM),
                         $urandom_range(0, LIM), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 1));
         end else begin
            // build a small cluster, then ask about voxels in and around it
            ax = border_biased();
            ay = border_biased();
            az = border_biased();
            n  = $urandom_range(3, 8);
            repeat (n)
               send_request(CMD_WRITE, jitter(ax), jitter(ay), jitter(az),
                            int'($urandom_range(0, 3) != 0),
                            $urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom_range(0, 1), $urandom_range(0, 1));
            n = $urandom_range(2, 5);
            repeat (n)
               send_request(CMD_QUERY, jitter(ax), jitter(ay), jitter(az),
                            $urandom_range(0, 1),
                            $urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom_range(0, 1), $urandom_range(0, 1));
         end
      end
      req_tvalid <= 1'b0;

      // let the checker see the last request before asking what is left
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (outstanding != 0)
         $display("%0d face masks never arrived", outstanding);
      $display("covered %0d writes and %0d queries, %0d masks with some faces hidden",
               writes_seen, queries_seen, partial_masks);
      $display("response side held off %0d time(s) for %0d cycles with requests pending",
               holds_done, HOLD_CYCLES);
      if (mismatches == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // response side: random ready bursts, one long hold-off on request
   initial begin : response_sink
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_wanted) begin
            // long stall so the block backs up and drops req_tready
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_wanted = 1'b0;
            holds_done++;
         end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // a correct run takes about 1 ms at worst: clearing pass, requests with both sides
   // stalling, and the long hold-off; allow 5 ms
   initial begin : watchdog
      #5_000_000;
      $display("timeout with %0d requests sent", requests_sent);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/vfv_pkg.sv
src/vfv_ram.sv
src/voxel_face_visibility_mask.sv
verif/vfv_checker.sv
verif/tb_voxel_face_visibility_mask.sv
